@@ rtl/mvps_pkg.sv @@
package mvps_pkg;

	localparam logic [31:0] CodePicture = 32'h0000_0100;
	localparam logic [31:0] CodeGop     = 32'h0000_01b8;
	localparam logic [31:0] CodeSeq     = 32'h0000_01b3;
	localparam logic [7:0]  FlagP       = 8'h22;
	localparam logic [7:0]  FlagB       = 8'h33;
	localparam logic [7:0]  FlagSeq     = 8'h40;
	localparam logic [7:0]  FlagClosed  = 8'h80;
	localparam logic [7:0]  FlagClamp   = 8'h04;
	localparam logic [2:0]  TypeMask    = 3'h7;
	localparam logic [7:0]  ClampValue  = 8'd127;
	localparam logic [39:0] BytesMax    = 40'hff_ffff_ffff;

	localparam logic [1:0] RegPicturesPerUnit = 2'd0;
	localparam logic [1:0] RegClipMode        = 2'd1;
	localparam logic [1:0] RegIndexEnabled    = 2'd2;

	localparam int QueueDepthDefault = 4;

	typedef enum logic [2:0] {
		PH_SCAN = 3'd0,
		PH_PIC1 = 3'd1,
		PH_PIC2 = 3'd2,
		PH_GOP1 = 3'd3,
		PH_GOP2 = 3'd4,
		PH_GOP3 = 3'd5,
		PH_GOP4 = 3'd6
	} phase_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] picture_number;
		logic [7:0]  anchor_offset;
		logic [7:0]  index_flags;
		logic [32:0] reorder_position;
		logic [10:0] reorder_offset;
		logic [39:0] unit_bytes;
		logic        edit_point;
		logic        stream_ended;
		logic        last_result;
	} result_t;

	// classified event passed from front to back
	typedef struct packed {
		logic        pic_valid;
		logic [31:0] pic_number;
		logic [31:0] anchor;
		logic [7:0]  flags;
		logic [9:0]  gop_pos;
		logic [9:0]  temporal_ref;
		logic        end_valid;
		logic [31:0] end_number;
		logic [39:0] end_bytes;
		logic        end_edit;
		logic        end_stream;
	} event_t;

endpackage

@@ rtl/mvps_stream_if.sv @@
interface mvps_stream_if #(
	parameter int Width = 9
);
	logic             valid;
	logic             ready;
	logic [Width-1:0] payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/mvps_front.sv @@
module mvps_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_stream,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        q_full,
	output logic        ev_push,
	output mvps_pkg::event_t ev
);

	logic        clip_mode_q;
	logic        index_enabled_q;
	logic [7:0]  ppu_q;
	logic [31:0] window_q;
	mvps_pkg::phase_t phase_q;
	logic [7:0]  pic_hi_q;
	logic        pic_found_q;
	logic        seen_seq_q;
	logic        gop_closed_q;
	logic [9:0]  gop_pos_q;
	logic [31:0] anchor_q;
	logic [31:0] pic_count_q;
	logic [7:0]  left_q;
	logic [39:0] bytes_q;
	logic        edit_q;
	logic        done_q;

	logic        take;
	logic [7:0]  unit_size;
	logic [31:0] win_next;
	logic        is_code;
	logic        pic_fin;
	logic [15:0] hdr;
	logic [2:0]  ptype;
	logic [7:0]  flags;
	logic [31:0] anchor_new;
	logic        boundary;
	logic        unit_cut;
	logic [39:0] bytes_inc;

	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;
	assign unit_size = (ppu_q == 8'd0) ? 8'd1 : ppu_q;
	assign win_next  = {window_q[23:0], data_byte};
	assign is_code   = win_next == mvps_pkg::CodePicture || win_next == mvps_pkg::CodeGop
		|| win_next == mvps_pkg::CodeSeq;
	assign bytes_inc = (bytes_q == mvps_pkg::BytesMax) ? bytes_q : bytes_q + 40'd1;

	// picture header completion, normal or cut short by end of stream
	always_comb begin
		pic_fin = 1'b0;
		hdr     = 16'd0;
		if (!done_q) begin
			if (end_of_stream) begin
				pic_fin = phase_q == mvps_pkg::PH_PIC1 || phase_q == mvps_pkg::PH_PIC2;
				hdr     = (phase_q == mvps_pkg::PH_PIC2) ? {pic_hi_q, 8'd0} : 16'd0;
			end else if (phase_q == mvps_pkg::PH_PIC2) begin
				pic_fin = 1'b1;
				hdr     = {pic_hi_q, data_byte};
			end
		end
	end

	assign ptype = hdr[5:3] & mvps_pkg::TypeMask;

	// flags and anchor for the entry
	always_comb begin
		anchor_new = anchor_q;
		case (ptype)
			3'd2: flags = mvps_pkg::FlagP;
			3'd3: flags = mvps_pkg::FlagB;
			default: begin
				flags      = 8'd0;
				anchor_new = pic_count_q;
			end
		endcase
		if (seen_seq_q) begin
			flags = flags | mvps_pkg::FlagSeq;
			if (gop_closed_q)
				flags = flags | mvps_pkg::FlagClosed;
		end
	end

	assign boundary = !done_q && !end_of_stream && phase_q == mvps_pkg::PH_SCAN
		&& pic_found_q && is_code;
	assign unit_cut = boundary && !clip_mode_q && left_q <= 8'd1;

	// event to the back part
	always_comb begin
		ev              = '0;
		ev.pic_valid    = pic_fin && index_enabled_q;
		ev.pic_number   = pic_count_q;
		ev.anchor       = anchor_new;
		ev.flags        = flags;
		ev.gop_pos      = gop_pos_q;
		ev.temporal_ref = hdr[15:6];
		if (!done_q && end_of_stream) begin
			ev.end_valid  = 1'b1;
			ev.end_number = pic_count_q + 32'd1;
			ev.end_bytes  = bytes_q;
			ev.end_edit   = edit_q || (pic_fin && seen_seq_q && gop_closed_q);
			ev.end_stream = 1'b1;
		end else if (unit_cut) begin
			ev.end_valid  = 1'b1;
			ev.end_number = pic_count_q + 32'd1;
			ev.end_bytes  = (bytes_inc == mvps_pkg::BytesMax) ? bytes_inc : bytes_inc - 40'd4;
			ev.end_edit   = edit_q;
		end
	end
	assign ev_push = take && (ev.pic_valid || ev.end_valid);

	// configuration and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppu_q <= 8'd1; clip_mode_q <= 1'b0; index_enabled_q <= 1'b0;
			window_q <= '1; phase_q <= mvps_pkg::PH_SCAN; pic_hi_q <= '0;
			pic_found_q <= 1'b0; seen_seq_q <= 1'b0; gop_closed_q <= 1'b0;
			gop_pos_q <= '0; anchor_q <= '0; pic_count_q <= '0; left_q <= 8'd1;
			bytes_q <= '0; edit_q <= 1'b0; done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mvps_pkg::RegPicturesPerUnit: begin
						ppu_q  <= cfg_data;
						left_q <= (cfg_data == 8'd0) ? 8'd1 : cfg_data;
					end
					mvps_pkg::RegClipMode:     clip_mode_q <= cfg_data[0];
					mvps_pkg::RegIndexEnabled: index_enabled_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (take && !done_q) begin
				if (pic_fin) begin
					if (seen_seq_q && gop_closed_q)
						edit_q <= 1'b1;
					if (index_enabled_q)
						anchor_q <= anchor_new;
					gop_pos_q <= gop_pos_q + 10'd1;
				end
				if (end_of_stream) begin
					phase_q     <= mvps_pkg::PH_SCAN;
					pic_count_q <= pic_count_q + 32'd1;
					left_q      <= unit_size;
					done_q      <= 1'b1;
				end else begin
					bytes_q <= bytes_inc;
					case (phase_q)
						mvps_pkg::PH_PIC1: begin
							pic_hi_q <= data_byte;
							phase_q  <= mvps_pkg::PH_PIC2;
						end
						mvps_pkg::PH_PIC2: begin
							phase_q  <= mvps_pkg::PH_SCAN;
							window_q <= '1;
						end
						mvps_pkg::PH_GOP1: phase_q <= mvps_pkg::PH_GOP2;
						mvps_pkg::PH_GOP2: phase_q <= mvps_pkg::PH_GOP3;
						mvps_pkg::PH_GOP3: phase_q <= mvps_pkg::PH_GOP4;
						mvps_pkg::PH_GOP4: begin
							gop_closed_q <= data_byte[6];
							phase_q      <= mvps_pkg::PH_SCAN;
							window_q     <= '1;
						end
						default: begin
							window_q <= win_next;
							phase_q  <= mvps_pkg::PH_SCAN;
							if (boundary) begin
								pic_count_q <= pic_count_q + 32'd1;
								if (!clip_mode_q) begin
									if (unit_cut) begin
										left_q  <= unit_size;
										bytes_q <= 40'd4;
									end else begin
										left_q <= left_q - 8'd1;
									end
								end
								pic_found_q <= 1'b0;
								edit_q      <= 1'b0;
								seen_seq_q  <= 1'b0;
							end
							if (!pic_found_q || boundary) begin
								if (win_next == mvps_pkg::CodePicture) begin
									pic_found_q <= 1'b1;
									phase_q     <= mvps_pkg::PH_PIC1;
								end else if (win_next == mvps_pkg::CodeGop) begin
									gop_pos_q <= '0;
									phase_q   <= mvps_pkg::PH_GOP1;
								end else if (win_next == mvps_pkg::CodeSeq) begin
									seen_seq_q <= 1'b1;
								end
							end
						end
					endcase
				end
			end
		end
	end

endmodule

@@ rtl/mvps_queue.sv @@
module mvps_queue #(
	parameter int Depth = mvps_pkg::QueueDepthDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mvps_pkg::event_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output mvps_pkg::event_t pop_data
);

	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	mvps_pkg::event_t mem_q [Depth];
	logic [AddrW-1:0] wr_q;
	logic [AddrW-1:0] rd_q;
	logic [AddrW:0]   count_q;

	assign full     = count_q == (AddrW+1)'(Depth);
	assign empty    = count_q == '0;
	assign pop_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty)
				rd_q <= (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			count_q <= count_q + (AddrW+1)'(push && !full) - (AddrW+1)'(pop && !empty);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !(push && !pop)) else $error("queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AddrW+1)'(Depth)) else $error("queue count out of range");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		empty |=> count_q <= (AddrW+1)'(1)) else $error("queue count jump");

endmodule

@@ rtl/mvps_back.sv @@
module mvps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  mvps_pkg::event_t q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output mvps_pkg::result_t out_data
);

	logic             half_q;
	logic             take_out;
	logic [31:0]      diff;
	logic             in_range;
	logic [10:0]      roff;
	mvps_pkg::result_t pic_r;
	mvps_pkg::result_t end_r;
	mvps_pkg::result_t next_r;
	logic             last_of_ev;

	assign take_out = !out_valid || out_ready;

	// entry fields
	always_comb begin
		diff     = q_data.anchor - q_data.pic_number;
		in_range = (diff[31:7] == '0) || (diff[31:7] == '1);
		roff     = {1'b0, q_data.gop_pos} - {1'b0, q_data.temporal_ref};
		pic_r                  = '0;
		pic_r.picture_number   = q_data.pic_number;
		pic_r.anchor_offset    = in_range ? diff[7:0] : mvps_pkg::ClampValue;
		pic_r.index_flags      = q_data.flags | (in_range ? 8'd0 : mvps_pkg::FlagClamp);
		pic_r.reorder_offset   = roff;
		pic_r.reorder_position = {1'b0, q_data.pic_number} - {{22{roff[10]}}, roff};
		pic_r.last_result      = !q_data.end_valid;
		end_r                  = '0;
		end_r.result_kind      = 1'b1;
		end_r.picture_number   = q_data.end_number;
		end_r.unit_bytes       = q_data.end_bytes;
		end_r.edit_point       = q_data.end_edit;
		end_r.stream_ended     = q_data.end_stream;
		end_r.last_result      = 1'b1;
		if (q_data.pic_valid && !half_q) begin
			next_r     = pic_r;
			last_of_ev = !q_data.end_valid;
		end else begin
			next_r     = end_r;
			last_of_ev = 1'b1;
		end
	end

	assign q_pop = !q_empty && take_out && last_of_ev;

	// output register and split of two-result events
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			half_q    <= 1'b0;
		end else if (take_out) begin
			out_valid <= !q_empty;
			if (!q_empty)
				half_q <= !last_of_ev;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out && !q_empty)
			out_data <= next_r;
	end

	a_half_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> q_data.end_valid) else $error("split without unit end");
	a_half_holds: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> !q_empty) else $error("split event lost");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind |-> out_data.last_result)
		else $error("unit end not last");

endmodule

@@ rtl/mpeg2_video_picture_splitter_top.sv @@
// MPEG-2 video picture splitter: takes one stream byte per transaction (one per clock
// while the queue has room) and finds sequence, GOP and picture start codes, giving
// per-picture index entries and edit unit ends. The front scanner holds all stream
// state and stalls input while the queue is full; events go through a small queue to
// the back part (one result per cycle while the receiver is ready); the queue absorbs
// two-result items. Configuration is taken in any cycle and applies to later bytes.
module mpeg2_video_picture_splitter_top #(
	parameter int QueueDepth = mvps_pkg::QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	mvps_stream_if.sink   in_ch,
	mvps_stream_if.source out_ch,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic             ev_push;
	mvps_pkg::event_t ev;
	mvps_pkg::event_t q_data;
	mvps_pkg::result_t res;

	assign cfg_ready = 1'b1;

	mvps_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.data_byte(in_ch.payload[7:0]), .end_of_stream(in_ch.payload[8]),
		.cfg_we(cfg_valid), .cfg_index, .cfg_data,
		.q_full, .ev_push, .ev
	);

	mvps_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .push(ev_push), .push_data(ev), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_data)
	);

	mvps_back u_back (
		.clk, .arst_n, .q_empty, .q_data, .q_pop,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(res)
	);

	assign out_ch.payload = res;

endmodule

@@ test/mvps_tb_stream_if.sv @@
`timescale 1ns / 1ps

// payload of the input channel: {end_of_stream, data_byte}
// payload of the output channel: mvps_pkg::result_t
// the channel interface itself is the one in rtl/mvps_stream_if.sv;
// this file only gathers the testbench's payload helpers
package mvps_tb_pkg;

	localparam int InWidth  = 9;
	localparam int OutWidth = $bits(mvps_pkg::result_t);

	function automatic logic [InWidth-1:0] pack_input(logic [7:0] data, logic eos);
		return {eos, data};
	endfunction
endpackage

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 30;

	// splitter predictor and pending picture/unit results
	class splitter_scoreboard;
		bit [7:0]  per_unit;
		bit        clip;
		bit        index_on;
		bit [31:0] window;
		mvps_pkg::phase_t phase;
		bit [7:0]  hdr_hi;
		bit        found;
		bit        seen_seq;
		bit        closed;
		bit [9:0]  gop_pos;
		bit [31:0] anchor;
		bit [31:0] pic_count;
		bit [7:0]  left;
		bit [39:0] unit_len;
		bit        edit;
		bit        done;
		mvps_pkg::result_t expected_q[$];
		int        errors;

		function new();
			per_unit = 8'd1;
			clip = 1'b0;
			index_on = 1'b0;
			window = '1;
			phase = mvps_pkg::PH_SCAN;
			hdr_hi = '0;
			found = 1'b0;
			seen_seq = 1'b0;
			closed = 1'b0;
			gop_pos = '0;
			anchor = '0;
			pic_count = '0;
			left = 8'd1;
			unit_len = '0;
			edit = 1'b0;
			done = 1'b0;
			errors = 0;
		endfunction

		function bit [7:0] unit_pictures();
			return (per_unit == 0) ? 8'd1 : per_unit;
		endfunction

		function void note_result(mvps_pkg::result_t r);
			expected_q = {expected_q, r};
		endfunction

		function void configure(logic [1:0] index, logic [7:0] data);
			case (index)
				mvps_pkg::RegPicturesPerUnit: begin
					per_unit = data;
					left = unit_pictures();
				end
				mvps_pkg::RegClipMode: clip = data[0];
				mvps_pkg::RegIndexEnabled: index_on = data[0];
				default: ;
			endcase
		endfunction

		// picture header complete: index entry and edit point tracking
		function void picture_entry(bit [7:0] hi, bit [7:0] lo);
			bit [15:0] hdr;
			bit [9:0]  tr;
			bit [2:0]  ptype;
			bit [7:0]  flags;
			bit [31:0] diff;
			int        off;
			int        roff;
			longint    rpos;
			mvps_pkg::result_t r;
			hdr = {hi, lo};
			tr = hdr[15:6];
			ptype = hdr[5:3] & mvps_pkg::TypeMask;
			if (seen_seq && closed)
				edit = 1'b1;
			if (index_on) begin
				if (ptype == 3'd2)
					flags = mvps_pkg::FlagP;
				else if (ptype == 3'd3)
					flags = mvps_pkg::FlagB;
				else begin
					anchor = pic_count;
					flags = 8'h00;
				end
				if (seen_seq) begin
					flags |= mvps_pkg::FlagSeq;
					if (closed)
						flags |= mvps_pkg::FlagClosed;
				end
				diff = anchor - pic_count;
				off = $signed(diff);
				if (off < -128 || off > 127) begin
					off = int'(mvps_pkg::ClampValue);
					flags |= mvps_pkg::FlagClamp;
				end
				roff = int'(gop_pos) - int'(tr);
				rpos = longint'(pic_count) - longint'(roff);
				r = '0;
				r.result_kind = 1'b0;
				r.picture_number = pic_count;
				r.anchor_offset = off[7:0];
				r.index_flags = flags;
				r.reorder_position = rpos[32:0];
				r.reorder_offset = roff[10:0];
				note_result(r);
			end
			gop_pos = gop_pos + 10'd1;
		endfunction

		function void unit_end(bit [39:0] len, bit ended);
			mvps_pkg::result_t r;
			r = '0;
			r.result_kind = 1'b1;
			r.picture_number = pic_count;
			r.unit_bytes = len;
			r.edit_point = edit;
			r.stream_ended = ended;
			note_result(r);
		endfunction

		// one accepted input transaction
		function void accept(bit [7:0] b, bit eos);
			int  first;
			bit  is_code;
			first = expected_q.size();
			if (done)
				return;
			if (eos) begin
				if (phase == mvps_pkg::PH_PIC1)
					picture_entry(8'h00, 8'h00);
				else if (phase == mvps_pkg::PH_PIC2)
					picture_entry(hdr_hi, 8'h00);
				phase = mvps_pkg::PH_SCAN;
				pic_count++;
				unit_end(unit_len, 1'b1);
				left = unit_pictures();
				done = 1'b1;
			end else begin
				if (unit_len != mvps_pkg::BytesMax)
					unit_len++;
				if (phase == mvps_pkg::PH_PIC1) begin
					hdr_hi = b;
					phase = mvps_pkg::PH_PIC2;
				end else if (phase == mvps_pkg::PH_PIC2) begin
					picture_entry(hdr_hi, b);
					phase = mvps_pkg::PH_SCAN;
					window = '1;
				end else if (phase >= mvps_pkg::PH_GOP1 && phase < mvps_pkg::PH_GOP4) begin
					phase = mvps_pkg::phase_t'(phase + 3'd1);
				end else if (phase == mvps_pkg::PH_GOP4) begin
					closed = b[6];
					phase = mvps_pkg::PH_SCAN;
					window = '1;
				end else begin
					phase = mvps_pkg::PH_SCAN;
					window = {window[23:0], b};
					is_code = window == mvps_pkg::CodePicture || window == mvps_pkg::CodeGop ||
						window == mvps_pkg::CodeSeq;
					if (found && is_code) begin
						pic_count++;
						if (!clip) begin
							if (left <= 8'd1) begin
								unit_end((unit_len == mvps_pkg::BytesMax) ? mvps_pkg::BytesMax
									: unit_len - 40'd4, 1'b0);
								left = unit_pictures();
								unit_len = 40'd4;
							end else
								left--;
						end
						found = 1'b0;
						seen_seq = 1'b0;
						edit = 1'b0;
					end
					if (!found) begin
						if (window == mvps_pkg::CodePicture) begin
							found = 1'b1;
							phase = mvps_pkg::PH_PIC1;
						end else if (window == mvps_pkg::CodeGop) begin
							gop_pos = '0;
							phase = mvps_pkg::PH_GOP1;
						end else if (window == mvps_pkg::CodeSeq)
							seen_seq = 1'b1;
					end
				end
			end
			if (expected_q.size() > first)
				expected_q[expected_q.size() - 1].last_result = 1'b1;
		endfunction

		function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check(mvps_pkg::result_t act);
			mvps_pkg::result_t exp_r;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction: 0x%0h", act);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			compare("result_kind", 64'(exp_r.result_kind), 64'(act.result_kind));
			compare("picture_number", 64'(exp_r.picture_number), 64'(act.picture_number));
			compare("anchor_offset", 64'(exp_r.anchor_offset), 64'(act.anchor_offset));
			compare("index_flags", 64'(exp_r.index_flags), 64'(act.index_flags));
			compare("reorder_position", 64'(exp_r.reorder_position),
				64'(act.reorder_position));
			compare("reorder_offset", 64'(exp_r.reorder_offset), 64'(act.reorder_offset));
			compare("unit_bytes", 64'(exp_r.unit_bytes), 64'(act.unit_bytes));
			compare("edit_point", 64'(exp_r.edit_point), 64'(act.edit_point));
			compare("stream_ended", 64'(exp_r.stream_ended), 64'(act.stream_ended));
			compare("last_result", 64'(exp_r.last_result), 64'(act.last_result));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	mvps_stream_if #(.Width(mvps_tb_pkg::InWidth))  in_ch ();
	mvps_stream_if #(.Width(mvps_tb_pkg::OutWidth)) out_ch ();

	mpeg2_video_picture_splitter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	splitter_scoreboard sb = new();
	bit [7:0] byte_q[$];
	int       burst_left = 0;
	bit       hold_request = 0;
	int       cycles = 0;

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin : receiver
		int mode;
		int mode_left;
		int hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				hold_left = 150;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else case (mode)
				0: out_ch.ready = 1'b1;
				1: out_ch.ready = 1'($urandom_range(0, 1));
				2: out_ch.ready = ($urandom_range(0, 7) != 0);
				default: out_ch.ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result monitor
	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check(out_ch.payload);

	// one input transaction, sent in bursts with random gaps
	task automatic send_item(bit [7:0] data, bit eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_ch.valid = 1'b1;
		in_ch.payload = mvps_tb_pkg::pack_input(data, eos);
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.accept(data, eos);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic send_stream();
		while (byte_q.size() > 0)
			send_item(byte_q.pop_front(), 1'b0);
		in_ch.valid = 1'b0;
	endtask

	task automatic write_reg(logic [1:0] index, logic [7:0] data);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.configure(index, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.expected_q.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// stream building blocks
	task automatic append_byte(bit [7:0] b);
		byte_q = {byte_q, b};
	endtask

	task automatic add_code(bit [7:0] code);
		append_byte(8'h00);
		append_byte(8'h00);
		append_byte(8'h01);
		append_byte(code);
	endtask

	task automatic add_body(int n);
		repeat (n)
			append_byte(($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
	endtask

	task automatic add_gop(bit is_closed);
		bit [7:0] last;
		add_code(mvps_pkg::CodeGop[7:0]);
		repeat (3) append_byte(8'($urandom));
		last = 8'($urandom);
		last[6] = is_closed;
		append_byte(last);
	endtask

	task automatic add_picture(bit [2:0] ptype, bit [9:0] tr, int body);
		add_code(mvps_pkg::CodePicture[7:0]);
		append_byte(tr[9:2]);
		append_byte({tr[1:0], ptype, 3'($urandom)});
		add_body(body);
	endtask

	function automatic bit [2:0] pick_type();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return 3'd1;
		if (r < 6) return 3'd2;
		if (r < 9) return 3'd3;
		return 3'($urandom);
	endfunction

	// mostly well-formed stream with random content, some noise
	task automatic random_stream(int target);
		int r;
		while (byte_q.size() < target) begin
			r = $urandom_range(0, 19);
			if (r < 2) begin
				add_code(mvps_pkg::CodeSeq[7:0]);
				add_body($urandom_range(0, 6));
				add_gop(1'($urandom_range(0, 1)));
			end else if (r < 4)
				add_gop(1'($urandom_range(0, 1)));
			else if (r < 17)
				add_picture(pick_type(), 10'($urandom), $urandom_range(0, 8));
			else if (r < 18) begin
				append_byte(8'h00);
				append_byte(8'h00);
				append_byte(8'h01);
			end else
				add_body($urandom_range(1, 6));
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		cfg_valid = 1'b0;
		cfg_index = mvps_pkg::RegPicturesPerUnit;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(mvps_pkg::RegIndexEnabled, 8'd1);
		write_reg(mvps_pkg::RegPicturesPerUnit, 8'd2);
		write_reg(mvps_pkg::RegClipMode, 8'd0);

		// directed: byte extremes, sequence header, closed gop, I, B and P pictures
		append_byte(8'hff);
		append_byte(8'h00);
		add_code(mvps_pkg::CodeSeq[7:0]);
		add_gop(1'b1);
		add_picture(3'd1, 10'd0, 0);
		append_byte(8'hff);
		append_byte(8'hff);
		add_picture(3'd3, 10'h3ff, 0);
		byte_q[byte_q.size() - 1] = 8'hff;
		add_picture(3'd2, 10'd1, 0);
		send_stream();
		drain();

		// random stream with one long receiver hold-off
		hold_request = 1;
		random_stream(250);
		send_stream();
		drain();

		// long run of P pictures past the anchor clamp
		write_reg(mvps_pkg::RegPicturesPerUnit, 8'd255);
		add_picture(3'd1, 10'd0, 0);
		repeat (130) add_picture(3'd2, 10'($urandom), 0);
		send_stream();
		drain();

		// clip mode: no unit ends until end of stream
		write_reg(mvps_pkg::RegClipMode, 8'd1);
		random_stream(150);
		send_stream();
		drain();

		// edit points only, one picture per unit
		write_reg(mvps_pkg::RegClipMode, 8'd0);
		write_reg(mvps_pkg::RegPicturesPerUnit, 8'd1);
		write_reg(mvps_pkg::RegIndexEnabled, 8'd0);
		random_stream(150);
		send_stream();
		drain();

		// index back on, end of stream inside a picture header
		write_reg(mvps_pkg::RegIndexEnabled, 8'd1);
		write_reg(mvps_pkg::RegPicturesPerUnit, 8'($urandom_range(2, 8)));
		random_stream(150);
		add_code(mvps_pkg::CodePicture[7:0]);
		append_byte(8'($urandom));
		send_stream();
		send_item(8'($urandom), 1'b1);
		in_ch.valid = 1'b0;
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
